// ----- rtl/clovl_pkg.sv -----
// Shared types, constants and codes for the clipped image overlay accumulator.
package clovl_pkg;

  localparam int unsigned COORD_W   = 8;
  localparam int unsigned MAX_WIDTH = 1 << COORD_W;
  localparam int unsigned ADDR_W    = 2 * COORD_W;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned SHIFT_W   = 10;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0]   DIM_MAX     = DIM_W'(MAX_WIDTH);
  localparam logic [PIX_W-1:0]   BLANK_RESET = 32'hFF9D_0000;
  localparam logic [PIX_W-1:0]   PIX_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [PIX_W-1:0]   PIX_NEG_MAX = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_MERGE = 2'd1,
    ACT_READ  = 2'd2
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_PATCH_WIDTH  = 3'd2,
    REG_PATCH_HEIGHT = 3'd3,
    REG_SHIFT_X      = 3'd4,
    REG_SHIFT_Y      = 3'd5,
    REG_BLANK_VALUE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [DIM_W-1:0]   patch_width;
    logic [DIM_W-1:0]   patch_height;
    logic [SHIFT_W-1:0] shift_x;
    logic [SHIFT_W-1:0] shift_y;
    logic [PIX_W-1:0]   blank_value;
  } cfg_t;

  // One decoded item as it travels down the pipeline
  typedef struct packed {
    act_t              act;
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
  } op_t;

endpackage

// ----- rtl/clovl_decode.sv -----
// Item decode: placement, clipping, blank test and store address.
module clovl_decode (
  input  clovl_pkg::cfg_t                   cfg,
  input  logic [1:0]                        action,
  input  logic [clovl_pkg::COORD_W-1:0]     column,
  input  logic [clovl_pkg::COORD_W-1:0]     line,
  input  logic [clovl_pkg::PIX_W-1:0]       pixel,
  output clovl_pkg::op_t                    op
);
  import clovl_pkg::*;

  localparam int unsigned POS_W = SHIFT_W + 1;

  logic [DIM_W-1:0] eff_w;
  logic [DIM_W-1:0] eff_h;
  logic [POS_W-1:0] dx;
  logic [POS_W-1:0] dy;
  logic             frame_in;
  logic             merge_in;

  always_comb begin
    eff_w = (cfg.frame_width  > DIM_MAX) ? DIM_MAX : cfg.frame_width;
    eff_h = (cfg.frame_height > DIM_MAX) ? DIM_MAX : cfg.frame_height;

    dx = POS_W'(column) + {cfg.shift_x[SHIFT_W-1], cfg.shift_x};
    dy = POS_W'(line)   + {cfg.shift_y[SHIFT_W-1], cfg.shift_y};

    frame_in = (DIM_W'(column) < eff_w) && (DIM_W'(line) < eff_h);

    // Sign bit clear means the target is not left of or above the frame
    merge_in = (DIM_W'(column) < cfg.patch_width) && (DIM_W'(line) < cfg.patch_height) &&
               !dx[POS_W-1] && !dy[POS_W-1] &&
               (dx[POS_W-2:0] < SHIFT_W'(eff_w)) && (dy[POS_W-2:0] < SHIFT_W'(eff_h)) &&
               (pixel != cfg.blank_value);

    op.act   = act_t'(action);
    op.pixel = pixel;
    op.hit   = 1'b0;
    op.addr  = {line, column};
    unique case (action) inside
      ACT_LOAD, ACT_READ: begin
        op.hit = frame_in;
      end
      ACT_MERGE: begin
        op.hit  = merge_in;
        op.addr = {dy[COORD_W-1:0], dx[COORD_W-1:0]};
      end
      default: begin
        op.hit = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/clovl_store.sv -----
// Pixel store: registered read, write port, forwarding of a write to the entry being read.
module clovl_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [clovl_pkg::ADDR_W-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [clovl_pkg::ADDR_W-1:0]  wr_addr,
  input  logic [clovl_pkg::PIX_W-1:0]   wr_data,
  output logic [clovl_pkg::PIX_W-1:0]   rd_data
);
  import clovl_pkg::*;

  logic [PIX_W-1:0] mem [1 << ADDR_W];
  logic [PIX_W-1:0] rd_data_r;
  logic [PIX_W-1:0] fwd_data_r;
  logic             fwd_hit_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= mem[rd_addr];
      if (wr_en) begin
        mem[wr_addr] <= wr_data;
      end
    end
  end

  // The array returns the old word when read and write meet; take the new one instead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (adv) begin
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_data_r;

endmodule

// ----- rtl/clovl_accum.sv -----
// Saturating Q16.16 accumulate of a merged pixel into a stored pixel.
module clovl_accum (
  input  logic [clovl_pkg::PIX_W-1:0] stored,
  input  logic [clovl_pkg::PIX_W-1:0] addend,
  output logic [clovl_pkg::PIX_W-1:0] sum,
  output logic                        clamped
);
  import clovl_pkg::*;

  logic [PIX_W:0] wide;

  always_comb begin
    wide    = {stored[PIX_W-1], stored} + {addend[PIX_W-1], addend};
    clamped = wide[PIX_W] != wide[PIX_W-1];
    if (clamped) begin
      sum = wide[PIX_W] ? PIX_NEG_MAX : PIX_POS_MAX;
    end else begin
      sum = wide[PIX_W-1:0];
    end
  end

endmodule

// ----- rtl/clipped_image_overlay_accumulate.sv -----
// Top level of the clipped image overlay accumulator.
//
//   channel  direction  accepted when            payload
//   in_      slave      in_tvalid & in_tready    tdata 48 b, tuser 2 b
//   out_     master     out_tvalid & out_tready  tdata 40 b
//   cfg_     write      cfg_wr_en                index 3 b, data 32 b
//
// One item per cycle sustained unless out_tready stalls; results leave via the output register.
// Stage A holds the decoded item and reads the store; stage B adds and writes back, and a
// write to the entry read in the same cycle is forwarded. The store is a single-port
// read / single-port write memory, which sets the one-item-per-cycle rate.
// rst_n (synchronous) clears the pipeline valids and loads the configuration defaults; store
// contents are undefined until loaded. A stall on out_tready freezes the whole pipeline.
module clipped_image_overlay_accumulate (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [47:0]                         in_tdata,   // column, line, pixel
  input  logic [1:0]                          in_tuser,   // action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [39:0]                         out_tdata,  // read_pixel, applied, saturated, pad
  input  logic                                cfg_wr_en,
  input  logic [clovl_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [clovl_pkg::PIX_W-1:0]         cfg_wdata
);
  import clovl_pkg::*;

  cfg_t             cfg_r;
  op_t              dec_op;
  op_t              a_op_r;
  logic             a_vld_r;
  op_t              b_op_r;
  logic             b_vld_r;
  logic             adv;
  logic [PIX_W-1:0] stored;
  logic [PIX_W-1:0] acc_sum;
  logic             acc_clamped;
  logic             b_we;
  logic [PIX_W-1:0] b_wdata;
  logic [PIX_W-1:0] res_pixel;
  logic             res_applied;
  logic             res_sat;
  logic             out_vld_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_applied_r;
  logic             out_sat_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= DIM_MAX;
      cfg_r.frame_height <= DIM_MAX;
      cfg_r.patch_width  <= DIM_MAX;
      cfg_r.patch_height <= DIM_MAX;
      cfg_r.shift_x      <= '0;
      cfg_r.shift_y      <= '0;
      cfg_r.blank_value  <= BLANK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata[DIM_W-1:0];
        REG_PATCH_WIDTH:  cfg_r.patch_width  <= cfg_wdata[DIM_W-1:0];
        REG_PATCH_HEIGHT: cfg_r.patch_height <= cfg_wdata[DIM_W-1:0];
        REG_SHIFT_X:      cfg_r.shift_x      <= cfg_wdata[SHIFT_W-1:0];
        REG_SHIFT_Y:      cfg_r.shift_y      <= cfg_wdata[SHIFT_W-1:0];
        REG_BLANK_VALUE:  cfg_r.blank_value  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance everything together whenever the output register can take a result
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  clovl_decode u_decode (
    .cfg    (cfg_r),
    .action (in_tuser),
    .column (in_tdata[7:0]),
    .line   (in_tdata[15:8]),
    .pixel  (in_tdata[47:16]),
    .op     (dec_op)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_tvalid;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_op_r <= dec_op;
      b_op_r <= a_op_r;
    end
  end

  assign b_we    = b_vld_r && b_op_r.hit && (b_op_r.act == ACT_LOAD || b_op_r.act == ACT_MERGE);
  assign b_wdata = (b_op_r.act == ACT_LOAD) ? b_op_r.pixel : acc_sum;

  clovl_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .rd_addr (a_op_r.addr),
    .wr_en   (b_we && adv),
    .wr_addr (b_op_r.addr),
    .wr_data (b_wdata),
    .rd_data (stored)
  );

  clovl_accum u_accum (
    .stored  (stored),
    .addend  (b_op_r.pixel),
    .sum     (acc_sum),
    .clamped (acc_clamped)
  );

  always_comb begin
    res_applied = b_op_r.hit;
    res_pixel   = (b_op_r.hit && b_op_r.act == ACT_READ) ? stored : '0;
    res_sat     = b_op_r.hit && b_op_r.act == ACT_MERGE && acc_clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r   <= res_pixel;
      out_applied_r <= res_applied;
      out_sat_r     <= res_sat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, out_sat_r, out_applied_r, out_pixel_r};

endmodule
